>>> hdl/cgqa_pkg.sv
// Shared types, codes and the exp fraction table for the causal GQA attention block.
`timescale 1ns / 1ps
package cgqa_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_Q = 2'd0,
    OP_LOAD_K = 2'd1,
    OP_LOAD_V = 2'd2,
    OP_RUN    = 2'd3
  } op_t;

  localparam logic [2:0] CFG_QUERY_HEADS    = 3'd0;
  localparam logic [2:0] CFG_KV_HEADS       = 3'd1;
  localparam logic [2:0] CFG_VECTOR_LENGTH  = 3'd2;
  localparam logic [2:0] CFG_START_POSITION = 3'd3;
  localparam logic [2:0] CFG_ROW_COUNT      = 3'd4;
  localparam logic [2:0] CFG_SCORE_SCALE    = 3'd5;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam logic [14:0] LOG2E_Q14 = 15'd23637;

  typedef struct packed {
    op_t                op;
    logic [7:0]         cache_position;
    logic [1:0]         kv_index;
    logic [5:0]         dim_index;
    logic signed [15:0] element;
    logic [4:0]         query_head;
    logic [8:0]         horizon;
    logic               bad;
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GRP,
    ST_KVH,
    ST_CHK,
    ST_ERR,
    ST_SISS,
    ST_SDRN,
    ST_SC2,
    ST_ERD,
    ST_EMUL,
    ST_EWR,
    ST_NRD,
    ST_NDIV,
    ST_NWAIT,
    ST_OISS,
    ST_ODRN,
    ST_OEMIT
  } state_t;

  typedef logic [16:0] frac_tab_t [256];

  // 2^(-i/256) in Q1.16, entry 0 is 1.0
  function automatic frac_tab_t build_frac_tab();
    frac_tab_t       tab;
    longint unsigned x;
    x = 64'd1 << 32;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 17'((x + 64'd32768) >> 16);
      x = (x * 64'd4283353945) >> 32;
    end
    return tab;
  endfunction

  localparam frac_tab_t FRAC_TAB = build_frac_tab();

endpackage

>>> hdl/cgqa_front.sv
// Front end: takes input transactions, drops bad loads, flags bad runs, queues commands.
`timescale 1ns / 1ps
module cgqa_front #(
  parameter int MAX_SEQ      = 256,
  parameter int MAX_KV_HEADS = 4,
  parameter int MAX_HEAD_DIM = 64
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_cache_position,
  input  logic [1:0]         in_kv_index,
  input  logic [5:0]         in_dim_index,
  input  logic signed [15:0] in_element,
  input  logic [7:0]         in_query_row,
  input  logic [4:0]         in_query_head,
  input  logic [5:0]         qh,
  input  logic [2:0]         kv,
  input  logic [6:0]         vl,
  input  logic [7:0]         sp,
  input  logic [8:0]         rc,
  input  logic               fifo_full,
  output logic               push,
  output cgqa_pkg::cmd_t     cmd
);
  import cgqa_pkg::*;

  op_t        op;
  logic [8:0] horizon;
  logic       load_ok;
  logic       bad;

  assign op      = op_t'(in_op);
  assign horizon = 9'(sp) + 9'(in_query_row) + 9'd1;

  always_comb begin
    case (op)
      OP_LOAD_Q: load_ok = 32'(in_dim_index) < MAX_HEAD_DIM;
      OP_LOAD_K, OP_LOAD_V:
        load_ok = (32'(in_cache_position) < MAX_SEQ) && (32'(in_kv_index) < MAX_KV_HEADS)
                  && (32'(in_dim_index) < MAX_HEAD_DIM);
      default: load_ok = 1'b1;
    endcase
  end

  assign bad = ({1'b0, in_query_head} >= qh) || ({1'b0, in_query_row} >= rc)
             || (32'(horizon) > MAX_SEQ) || (kv == 3'd0) || ({3'b0, kv} > qh)
             || (32'(kv) > MAX_KV_HEADS) || (vl == 7'd0) || (32'(vl) > MAX_HEAD_DIM);

  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full && load_ok;

  always_comb begin
    cmd.op             = op;
    cmd.cache_position = in_cache_position;
    cmd.kv_index       = in_kv_index;
    cmd.dim_index      = in_dim_index;
    cmd.element        = in_element;
    cmd.query_head     = in_query_head;
    cmd.horizon        = horizon;
    cmd.bad            = bad;
  end

endmodule

>>> hdl/cgqa_fifo.sv
// Short command queue between front and back end.
`timescale 1ns / 1ps
module cgqa_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cgqa_pkg::cmd_t wdata,
  input  logic           pop,
  output cgqa_pkg::cmd_t rdata,
  output logic           full,
  output logic           not_empty
);
  import cgqa_pkg::*;

  cmd_t             mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;

  assign full      = cnt_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign not_empty = cnt_r != '0;
  assign rdata     = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
  end

endmodule

>>> hdl/cgqa_div.sv
// Restoring divider: quotient of dividend*2^16 by divisor, one bit per cycle.
`timescale 1ns / 1ps
module cgqa_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [16:0] dividend,
  input  logic [24:0] divisor,
  output logic        done,
  output logic [16:0] quotient
);

  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [25:0] rem_r, rem_nxt, trial;
  logic [24:0] div_r, div_nxt;
  logic [16:0] q_r, q_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  assign done     = done_r;
  assign quotient = q_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    // first step places the integer bit, later steps bring in zeros
    trial    = (cnt_r == 5'd0) ? rem_r : {rem_r[24:0], 1'b0};
    if (start) begin
      busy_nxt = 1'b1;
      rem_nxt  = 26'(dividend);
      div_nxt  = divisor;
      q_nxt    = '0;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (trial >= 26'(div_r)) begin
        rem_nxt = trial - 26'(div_r);
        q_nxt   = {q_r[15:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd16) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    q_r   <= q_nxt;
  end

endmodule

>>> hdl/cgqa_back.sv
// Back end: stores, score/softmax/output sequencer and the result register.
`timescale 1ns / 1ps
module cgqa_back #(
  parameter int MAX_SEQ      = 256,
  parameter int MAX_KV_HEADS = 4,
  parameter int MAX_HEAD_DIM = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cgqa_pkg::cmd_t     cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  logic [5:0]         qh,
  input  logic [2:0]         kv,
  input  logic [6:0]         vl,
  input  logic [15:0]        scale,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_element,
  output logic [5:0]         out_dim,
  output logic               out_last,
  output logic               out_error
);
  import cgqa_pkg::*;

  localparam int DEPTH = MAX_SEQ * MAX_KV_HEADS * MAX_HEAD_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int QW    = (MAX_HEAD_DIM > 1) ? $clog2(MAX_HEAD_DIM) : 1;
  localparam int SW    = $clog2(MAX_SEQ);
  localparam logic [AW-1:0] STRIDE = AW'(MAX_KV_HEADS * MAX_HEAD_DIM);

  state_t state_r, state_nxt;

  logic [8:0]  hz_r, hz_nxt;
  logic [4:0]  head_r, head_nxt;
  logic [5:0]  rem_r, rem_nxt, grp_r, grp_nxt;
  logic [4:0]  kvh_r, kvh_nxt;
  logic [8:0]  t_r, t_nxt;
  logic [6:0]  d_r, d_nxt;
  logic [AW-1:0] base_r, base_nxt, addr_r, addr_nxt;
  logic signed [15:0] max_r, max_nxt;
  logic [24:0] sum_r, sum_nxt;
  logic [16:0] y_r, y_nxt;

  // dot product pipe
  logic               v1_r, v1_nxt, v2_r;
  logic signed [33:0] prod_r, prod_nxt;
  logic signed [39:0] acc_r, acc_nxt;
  logic signed [38:0] phi_r, phi_nxt;
  logic [33:0]        plo_r, plo_nxt;

  // result register
  logic               ov_r, ov_nxt, olast_r, olast_nxt, oerr_r, oerr_nxt;
  logic signed [15:0] oel_r, oel_nxt;
  logic [5:0]         odim_r, odim_nxt;

  // stores
  logic signed [15:0] q_mem [MAX_HEAD_DIM];
  logic signed [15:0] k_mem [DEPTH];
  logic signed [15:0] v_mem [DEPTH];
  logic [16:0]        sc_mem [MAX_SEQ];
  logic signed [15:0] q_rd_r, k_rd_r, v_rd_r;
  logic [16:0]        sc_rd_r;
  logic q_we, k_we, v_we, sc_we;
  logic [16:0]        sc_wdata;
  logic [AW-1:0]      load_addr, kv_off;

  logic        div_start, div_done;
  logic [16:0] div_q;
  logic [24:0] divisor;

  logic               score_side;
  logic signed [17:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [33:0] mul_w;
  logic signed [57:0] tot, tot_sh;
  logic signed [15:0] score;
  logic signed [39:0] acc_sh;
  logic signed [15:0] outv;
  logic [15:0]        diff;
  logic [30:0]        ymul;
  logic [8:0]         nshift;
  logic [16:0]        e_val;
  logic               out_free, t_last, d_last;

  assign load_addr = AW'((32'(cmd.cache_position) * MAX_KV_HEADS + 32'(cmd.kv_index))
                         * MAX_HEAD_DIM + 32'(cmd.dim_index));
  assign kv_off    = AW'(32'(kvh_r) * MAX_HEAD_DIM);
  assign out_free  = !ov_r || !out_stall;
  assign t_last    = t_r == hz_r - 9'd1;
  assign d_last    = d_r == vl - 7'd1;
  assign divisor   = (sum_r == '0) ? 25'd1 : sum_r;

  assign score_side = (state_r == ST_SISS) || (state_r == ST_SDRN);
  assign mul_a = score_side ? {{2{q_rd_r[15]}}, q_rd_r} : $signed({1'b0, sc_rd_r});
  assign mul_b = score_side ? k_rd_r : v_rd_r;
  assign mul_w = mul_a * mul_b;

  // score = floor(dot*scale / 2^30), saturated
  assign tot    = (58'(phi_r) <<< 18) + $signed({24'b0, plo_r});
  assign tot_sh = tot >>> 30;
  assign score  = (tot_sh > 58'sd32767) ? 16'sh7fff :
                  (tot_sh < -58'sd32768) ? -16'sd32768 : 16'(tot_sh);

  assign acc_sh = acc_r >>> 16;
  assign outv   = (acc_sh > 40'sd32767) ? 16'sh7fff :
                  (acc_sh < -40'sd32768) ? -16'sd32768 : 16'(acc_sh);

  assign diff   = 16'(17'(max_r) - 17'($signed(sc_rd_r[15:0])));
  assign ymul   = 31'(diff) * 31'(LOG2E_Q14);
  assign nshift = y_r[16:8];
  assign e_val  = (nshift >= 9'd17) ? 17'd0 : (FRAC_TAB[y_r[7:0]] >> nshift);

  cgqa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sc_rd_r),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    hz_nxt    = hz_r;
    head_nxt  = head_r;
    rem_nxt   = rem_r;
    grp_nxt   = grp_r;
    kvh_nxt   = kvh_r;
    t_nxt     = t_r;
    d_nxt     = d_r;
    base_nxt  = base_r;
    addr_nxt  = addr_r;
    max_nxt   = max_r;
    sum_nxt   = sum_r;
    y_nxt     = y_r;
    phi_nxt   = phi_r;
    plo_nxt   = plo_r;
    cmd_pop   = 1'b0;
    q_we      = 1'b0;
    k_we      = 1'b0;
    v_we      = 1'b0;
    sc_we     = 1'b0;
    sc_wdata  = '0;
    div_start = 1'b0;
    v1_nxt    = 1'b0;
    prod_nxt  = v1_r ? mul_w : prod_r;
    acc_nxt   = v2_r ? acc_r + 40'(prod_r) : acc_r;
    ov_nxt    = (ov_r && !out_stall) ? 1'b0 : ov_r;
    oel_nxt   = oel_r;
    odim_nxt  = odim_r;
    olast_nxt = olast_r;
    oerr_nxt  = oerr_r;

    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            OP_LOAD_Q: q_we = 1'b1;
            OP_LOAD_K: k_we = 1'b1;
            OP_LOAD_V: v_we = 1'b1;
            default: begin
              hz_nxt   = cmd.horizon;
              head_nxt = cmd.query_head;
              rem_nxt  = qh;
              grp_nxt  = '0;
              state_nxt = cmd.bad ? ST_ERR : ST_GRP;
            end
          endcase
        end
      end
      // groups = query_heads / kv_heads by repeated subtraction
      ST_GRP: begin
        if (rem_r >= 6'(kv)) begin
          rem_nxt = rem_r - 6'(kv);
          grp_nxt = grp_r + 6'd1;
        end else begin
          rem_nxt   = 6'(head_r);
          kvh_nxt   = '0;
          state_nxt = ST_KVH;
        end
      end
      ST_KVH: begin
        if (rem_r >= grp_r) begin
          rem_nxt = rem_r - grp_r;
          kvh_nxt = kvh_r + 5'd1;
        end else begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        if (kvh_r >= 5'(kv)) begin
          state_nxt = ST_ERR;
        end else begin
          t_nxt     = '0;
          d_nxt     = '0;
          base_nxt  = kv_off;
          addr_nxt  = kv_off;
          max_nxt   = -16'sd32768;
          sum_nxt   = '0;
          state_nxt = ST_SISS;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oel_nxt   = '0;
          odim_nxt  = '0;
          olast_nxt = 1'b1;
          oerr_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SISS: begin
        v1_nxt = 1'b1;
        if (d_r == 7'd0) acc_nxt = '0;
        if (d_last) begin
          state_nxt = ST_SDRN;
        end else begin
          d_nxt    = d_r + 7'd1;
          addr_nxt = addr_r + 1'b1;
        end
      end
      ST_SDRN: begin
        if (!v1_r && !v2_r) begin
          phi_nxt   = $signed(acc_r[39:18]) * $signed({1'b0, scale});
          plo_nxt   = 34'(acc_r[17:0]) * 34'(scale);
          state_nxt = ST_SC2;
        end
      end
      ST_SC2: begin
        sc_we    = 1'b1;
        sc_wdata = 17'(score);
        if (score > max_r) max_nxt = score;
        if (t_last) begin
          t_nxt     = '0;
          state_nxt = ST_ERD;
        end else begin
          t_nxt     = t_r + 9'd1;
          d_nxt     = '0;
          base_nxt  = base_r + STRIDE;
          addr_nxt  = base_r + STRIDE;
          state_nxt = ST_SISS;
        end
      end
      ST_ERD: state_nxt = ST_EMUL;
      ST_EMUL: begin
        y_nxt     = 17'(ymul >> 14);
        state_nxt = ST_EWR;
      end
      ST_EWR: begin
        sc_we    = 1'b1;
        sc_wdata = e_val;
        sum_nxt  = sum_r + 25'(e_val);
        if (t_last) begin
          t_nxt     = '0;
          state_nxt = ST_NRD;
        end else begin
          t_nxt     = t_r + 9'd1;
          state_nxt = ST_ERD;
        end
      end
      ST_NRD: state_nxt = ST_NDIV;
      ST_NDIV: begin
        div_start = 1'b1;
        state_nxt = ST_NWAIT;
      end
      ST_NWAIT: begin
        if (div_done) begin
          sc_we    = 1'b1;
          sc_wdata = div_q;
          if (t_last) begin
            t_nxt     = '0;
            d_nxt     = '0;
            base_nxt  = kv_off;
            addr_nxt  = kv_off;
            state_nxt = ST_OISS;
          end else begin
            t_nxt     = t_r + 9'd1;
            state_nxt = ST_NRD;
          end
        end
      end
      ST_OISS: begin
        v1_nxt = 1'b1;
        if (t_r == 9'd0) acc_nxt = '0;
        if (t_last) begin
          state_nxt = ST_ODRN;
        end else begin
          t_nxt    = t_r + 9'd1;
          addr_nxt = addr_r + STRIDE;
        end
      end
      ST_ODRN: begin
        if (!v1_r && !v2_r) state_nxt = ST_OEMIT;
      end
      ST_OEMIT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oel_nxt   = outv;
          odim_nxt  = d_r[5:0];
          olast_nxt = d_last;
          oerr_nxt  = 1'b0;
          if (d_last) begin
            state_nxt = ST_IDLE;
          end else begin
            d_nxt     = d_r + 7'd1;
            t_nxt     = '0;
            base_nxt  = base_r + 1'b1;
            addr_nxt  = base_r + 1'b1;
            state_nxt = ST_OISS;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= v1_nxt;
      v2_r    <= v1_r;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hz_r    <= hz_nxt;
    head_r  <= head_nxt;
    rem_r   <= rem_nxt;
    grp_r   <= grp_nxt;
    kvh_r   <= kvh_nxt;
    t_r     <= t_nxt;
    d_r     <= d_nxt;
    base_r  <= base_nxt;
    addr_r  <= addr_nxt;
    max_r   <= max_nxt;
    sum_r   <= sum_nxt;
    y_r     <= y_nxt;
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    phi_r   <= phi_nxt;
    plo_r   <= plo_nxt;
    oel_r   <= oel_nxt;
    odim_r  <= odim_nxt;
    olast_r <= olast_nxt;
    oerr_r  <= oerr_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[QW'(cmd.dim_index)] <= cmd.element;
    q_rd_r <= q_mem[QW'(d_r)];
  end

  always_ff @(posedge clk) begin
    if (k_we) k_mem[load_addr] <= cmd.element;
    k_rd_r <= k_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (v_we) v_mem[load_addr] <= cmd.element;
    v_rd_r <= v_mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (sc_we) sc_mem[SW'(t_r)] <= sc_wdata;
    sc_rd_r <= sc_mem[SW'(t_r)];
  end

  assign out_valid   = ov_r;
  assign out_element = oel_r;
  assign out_dim     = odim_r;
  assign out_last    = olast_r;
  assign out_error   = oerr_r;

endmodule

>>> hdl/causal_gqa_attention.sv
// Causal grouped-query attention over a Q4.11 key/value cache.
// Loads: one transaction per cycle, no result; they wait only while the 4-deep queue is full.
// Run: paced by one read port per store and the 17-step divider; a front-flagged error
//   goes from the queue through the error state into the result register.
// Reset (rst_n low, synchronous): config registers to defaults, queue emptied, no result pending;
//   the stores are not cleared and hold garbage until loaded.
`timescale 1ns / 1ps
module causal_gqa_attention #(
  parameter int MAX_SEQ      = 256,
  parameter int MAX_KV_HEADS = 4,
  parameter int MAX_HEAD_DIM = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_cache_position,
  input  logic [1:0]         in_kv_index,
  input  logic [5:0]         in_dim_index,
  input  logic signed [15:0] in_element,
  input  logic [7:0]         in_query_row,
  input  logic [4:0]         in_query_head,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_element,
  output logic [5:0]         out_dim,
  output logic               out_last,
  output logic               out_error
);
  import cgqa_pkg::*;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  logic [5:0]  qh_r, qh_nxt;
  logic [2:0]  kv_r, kv_nxt;
  logic [6:0]  vl_r, vl_nxt;
  logic [7:0]  sp_r, sp_nxt;
  logic [8:0]  rc_r, rc_nxt;
  logic [15:0] scale_r, scale_nxt;

  cmd_t push_cmd, head_cmd;
  logic push, pop, fifo_full, fifo_ne;

  always_comb begin
    qh_nxt    = qh_r;
    kv_nxt    = kv_r;
    vl_nxt    = vl_r;
    sp_nxt    = sp_r;
    rc_nxt    = rc_r;
    scale_nxt = scale_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_QUERY_HEADS:    qh_nxt    = cfg_data[5:0];
        CFG_KV_HEADS:       kv_nxt    = cfg_data[2:0];
        CFG_VECTOR_LENGTH:  vl_nxt    = cfg_data[6:0];
        CFG_START_POSITION: sp_nxt    = cfg_data[7:0];
        CFG_ROW_COUNT:      rc_nxt    = cfg_data[8:0];
        CFG_SCORE_SCALE:    scale_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qh_r    <= 6'd1;
      kv_r    <= 3'd1;
      vl_r    <= 7'd64;
      sp_r    <= 8'd0;
      rc_r    <= 9'd1;
      scale_r <= 16'd8192;
    end else begin
      qh_r    <= qh_nxt;
      kv_r    <= kv_nxt;
      vl_r    <= vl_nxt;
      sp_r    <= sp_nxt;
      rc_r    <= rc_nxt;
      scale_r <= scale_nxt;
    end
  end

  // front: classify each transaction, queue runs and legal loads
  cgqa_front #(
    .MAX_SEQ      (MAX_SEQ),
    .MAX_KV_HEADS (MAX_KV_HEADS),
    .MAX_HEAD_DIM (MAX_HEAD_DIM)
  ) u_front (
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_cache_position (in_cache_position),
    .in_kv_index       (in_kv_index),
    .in_dim_index      (in_dim_index),
    .in_element        (in_element),
    .in_query_row      (in_query_row),
    .in_query_head     (in_query_head),
    .qh                (qh_r),
    .kv                (kv_r),
    .vl                (vl_r),
    .sp                (sp_r),
    .rc                (rc_r),
    .fifo_full         (fifo_full),
    .push              (push),
    .cmd               (push_cmd)
  );

  cgqa_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (push_cmd),
    .pop       (pop),
    .rdata     (head_cmd),
    .full      (fifo_full),
    .not_empty (fifo_ne)
  );

  // back: loads land in the stores, runs walk the cache
  cgqa_back #(
    .MAX_SEQ      (MAX_SEQ),
    .MAX_KV_HEADS (MAX_KV_HEADS),
    .MAX_HEAD_DIM (MAX_HEAD_DIM)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (head_cmd),
    .cmd_valid   (fifo_ne),
    .cmd_pop     (pop),
    .qh          (qh_r),
    .kv          (kv_r),
    .vl          (vl_r),
    .scale       (scale_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_element (out_element),
    .out_dim     (out_dim),
    .out_last    (out_last),
    .out_error   (out_error)
  );

endmodule

>>> hdl/cgqa_checker.sv
// Port-level checks for the attention block, bound to the top level.
`timescale 1ns / 1ps
module cgqa_sva (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_element,
  input logic [5:0]         out_dim,
  input logic               out_last,
  input logic               out_error
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_element) && $stable(out_dim)
      && $stable(out_last) && $stable(out_error))
    else $error("result changed under stall");

  // error results are a single, zeroed, final transaction
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && out_dim == 6'd0 && out_element == 16'sd0)
    else $error("malformed error result");

  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind causal_gqa_attention cgqa_sva u_cgqa_sva (.*);

>>> sim/cgqa_checker.sv
// Result checker and reference predictor for the causal GQA attention block.
`timescale 1ns / 1ps
module cgqa_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_cache_position,
  input  logic [1:0]         in_kv_index,
  input  logic [5:0]         in_dim_index,
  input  logic signed [15:0] in_element,
  input  logic [7:0]         in_query_row,
  input  logic [4:0]         in_query_head,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_element,
  input  logic [5:0]         out_dim,
  input  logic               out_last,
  input  logic               out_error,
  output int                 fail_count,
  output int                 pending,
  output int                 runs_seen,
  output int                 err_results,
  output int                 results_seen
);
  import cgqa_pkg::*;

  typedef struct {
    logic signed [15:0] elem;
    logic [5:0]         dim;
    logic               last;
    logic               err;
  } attn_result_t;

  attn_result_t       attn_results_due[$];
  logic signed [15:0] q_vec [64];
  logic signed [15:0] k_cache [65536];
  logic signed [15:0] v_cache [65536];
  int unsigned        pow2_frac [256];

  logic [5:0]  n_qheads;
  logic [2:0]  n_kvheads;
  logic [6:0]  vec_len;
  logic [7:0]  start_pos;
  logic [8:0]  n_rows;
  logic [15:0] scale;

  initial begin
    longint unsigned x;
    x = 64'd1 << 32;
    for (int i = 0; i < 256; i++) begin
      pow2_frac[i] = int'((x + 64'd32768) >> 16);
      x = (x * 64'd4283353945) >> 32;
    end
    fail_count = 0;
    runs_seen = 0;
    err_results = 0;
    results_seen = 0;
  end

  assign pending = attn_results_due.size();

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic push_error();
    attn_result_t r;
    r.elem = '0;
    r.dim  = '0;
    r.last = 1'b1;
    r.err  = 1'b1;
    attn_results_due.push_back(r);
  endtask

  // softmax-weighted sum of value rows up to the causal horizon
  task automatic predict_attention(logic [7:0] row, logic [4:0] head);
    int unsigned     horizon, groups, kvh, addr, diff, y, sh;
    longint          dot, s, maxs, acc;
    longint unsigned total;
    longint          score [256];
    longint unsigned wt [256];
    attn_result_t    r;
    if (head >= n_qheads || row >= n_rows) begin
      push_error();
      return;
    end
    horizon = start_pos + row + 1;
    if (horizon > 256 || n_kvheads == 0 || n_kvheads > n_qheads || n_kvheads > 4 ||
        vec_len == 0 || vec_len > 64) begin
      push_error();
      return;
    end
    groups = n_qheads / n_kvheads;
    kvh = head / groups;
    if (kvh >= n_kvheads) begin
      push_error();
      return;
    end
    maxs = -32768;
    for (int t = 0; t < horizon; t++) begin
      dot = 0;
      for (int d = 0; d < vec_len; d++) begin
        addr = (t * 4 + kvh) * 64 + d;
        dot += longint'(q_vec[d]) * longint'(k_cache[addr]);
      end
      s = sat16((dot * longint'(scale)) >>> 30);
      score[t] = s;
      if (s > maxs) maxs = s;
    end
    total = 0;
    for (int t = 0; t < horizon; t++) begin
      diff = int'(maxs - score[t]);
      y = int'((longint'(diff) * 23637) >> 14);
      sh = y >> 8;
      wt[t] = (sh >= 17) ? 0 : (pow2_frac[y & 255] >> sh);
      total += wt[t];
    end
    if (total == 0) total = 1;
    for (int t = 0; t < horizon; t++) wt[t] = (wt[t] << 16) / total;
    for (int d = 0; d < vec_len; d++) begin
      acc = 0;
      for (int t = 0; t < horizon; t++) begin
        addr = (t * 4 + kvh) * 64 + d;
        acc += longint'(wt[t]) * longint'(v_cache[addr]);
      end
      r.elem = 16'(sat16(acc >>> 16));
      r.dim  = 6'(d);
      r.last = (d + 1 == vec_len);
      r.err  = 1'b0;
      attn_results_due.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    attn_result_t e;
    int unsigned  addr;
    if (!rst_n) begin
      n_qheads  <= 6'd1;
      n_kvheads <= 3'd1;
      vec_len   <= 7'd64;
      start_pos <= 8'd0;
      n_rows    <= 9'd1;
      scale     <= 16'd8192;
      attn_results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUERY_HEADS:    n_qheads  <= cfg_data[5:0];
          CFG_KV_HEADS:       n_kvheads <= cfg_data[2:0];
          CFG_VECTOR_LENGTH:  vec_len   <= cfg_data[6:0];
          CFG_START_POSITION: start_pos <= cfg_data[7:0];
          CFG_ROW_COUNT:      n_rows    <= cfg_data[8:0];
          CFG_SCORE_SCALE:    scale     <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        addr = (in_cache_position * 4 + in_kv_index) * 64 + in_dim_index;
        case (op_t'(in_op))
          OP_LOAD_Q: q_vec[in_dim_index] = in_element;
          OP_LOAD_K: k_cache[addr] = in_element;
          OP_LOAD_V: v_cache[addr] = in_element;
          OP_RUN: begin
            runs_seen++;
            predict_attention(in_query_row, in_query_head);
          end
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_error) err_results++;
        if (attn_results_due.size() == 0) begin
          $error("unexpected result: element %0d dim %0d", out_element, out_dim);
          fail_count++;
        end else begin
          e = attn_results_due.pop_front();
          if (out_element !== e.elem) begin
            $error("out_element expected %0d got %0d", e.elem, out_element);
            fail_count++;
          end
          if (out_dim !== e.dim) begin
            $error("out_dim expected %0d got %0d", e.dim, out_dim);
            fail_count++;
          end
          if (out_last !== e.last) begin
            $error("out_last expected %0d got %0d", e.last, out_last);
            fail_count++;
          end
          if (out_error !== e.err) begin
            $error("out_error expected %0d got %0d", e.err, out_error);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

>>> sim/tb_causal_gqa_attention.sv
// Stimulus and verdict for the causal GQA attention block.
`timescale 1ns / 1ps
module tb_causal_gqa_attention;
  import cgqa_pkg::*;

  // index past the register list, must be dropped by the block
  localparam logic [2:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [2:0] CFG_UNUSED_HI = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_op = OP_LOAD_Q;
  logic [7:0]         in_cache_position = '0;
  logic [1:0]         in_kv_index = '0;
  logic [5:0]         in_dim_index = '0;
  logic signed [15:0] in_element = '0;
  logic [7:0]         in_query_row = '0;
  logic [4:0]         in_query_head = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_element;
  logic [5:0]         out_dim;
  logic               out_last;
  logic               out_error;

  int fail_count, pending, runs_seen, err_results, results_seen;

  // quiet: no idling on either side during the closing stretch
  bit quiet = 1'b0;

  // which cache entries hold loaded data; a legal run only reads written ones
  bit k_written [65536];
  bit v_written [65536];

  // shadow of the register file, used to pick legal runs and fill the cache
  int unsigned qheads_sh, kvheads_sh, veclen_sh, start_sh, rows_sh;

  always #6 clk = ~clk;

  causal_gqa_attention i_dut (.*);

  cgqa_checker i_checker (.*);

  // receiver side: random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!quiet) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  // hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // one input transaction; returns at the accepting edge with valid still high
  task automatic send(op_t op, logic [7:0] pos, logic [1:0] kv, logic [5:0] dim,
                      logic [15:0] elem, logic [7:0] row, logic [4:0] head);
    int unsigned addr;
    bit          taken;
    addr = (pos * 4 + kv) * 64 + dim;
    in_op             <= op;
    in_cache_position <= pos;
    in_kv_index       <= kv;
    in_dim_index      <= dim;
    in_element        <= elem;
    in_query_row      <= row;
    in_query_head     <= head;
    in_valid          <= 1'b1;
    // stall only moves at rising edges, so its mid-cycle value is the one the edge sees
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (op == OP_LOAD_K) k_written[addr] = 1'b1;
    if (op == OP_LOAD_V) v_written[addr] = 1'b1;
  endtask

  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic send_load(op_t op, logic [7:0] pos, logic [1:0] kv, logic [5:0] dim,
                           logic [15:0] elem);
    maybe_idle();
    send(op, pos, kv, dim, elem, 8'($urandom), 5'($urandom));
  endtask

  // load every key/value entry a run with this horizon will read
  task automatic fill_cache(int unsigned kvh, int unsigned horizon, int unsigned vl);
    int unsigned addr;
    for (int t = 0; t < horizon; t++)
      for (int d = 0; d < vl; d++) begin
        addr = (t * 4 + kvh) * 64 + d;
        if (!k_written[addr]) send_load(OP_LOAD_K, 8'(t), 2'(kvh), 6'(d), 16'($urandom));
        if (!v_written[addr]) send_load(OP_LOAD_V, 8'(t), 2'(kvh), 6'(d), 16'($urandom));
      end
  endtask

  task automatic issue_run(int unsigned row, int unsigned head);
    int unsigned horizon, kvh;
    horizon = start_sh + row + 1;
    if (head < qheads_sh && row < rows_sh && horizon <= 256 && kvheads_sh != 0 &&
        kvheads_sh <= qheads_sh && kvheads_sh <= 4 && veclen_sh != 0 && veclen_sh <= 64) begin
      kvh = head / (qheads_sh / kvheads_sh);
      if (kvh < kvheads_sh) fill_cache(kvh, horizon, veclen_sh);
    end
    maybe_idle();
    send(OP_RUN, 8'($urandom), 2'($urandom), 6'($urandom), 16'($urandom), 8'(row), 5'(head));
  endtask

  // drop valid and wait until every result is back and queued loads have retired
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(val);
    case (idx)
      CFG_QUERY_HEADS:    qheads_sh  = val & 6'h3F;
      CFG_KV_HEADS:       kvheads_sh = val & 3'h7;
      CFG_VECTOR_LENGTH:  veclen_sh  = val & 7'h7F;
      CFG_START_POSITION: start_sh   = val & 8'hFF;
      CFG_ROW_COUNT:      rows_sh    = val & 9'h1FF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(int unsigned qh, int unsigned kv, int unsigned vl,
                           int unsigned sp, int unsigned rc, int unsigned sc);
    drain();
    write_reg(CFG_QUERY_HEADS, qh);
    write_reg(CFG_KV_HEADS, kv);
    write_reg(CFG_VECTOR_LENGTH, vl);
    write_reg(CFG_START_POSITION, sp);
    write_reg(CFG_ROW_COUNT, rc);
    write_reg(CFG_SCORE_SCALE, sc);
    @(posedge clk);
  endtask

  initial begin
    int unsigned qh, kv, pick;
    qheads_sh = 1; kvheads_sh = 1; veclen_sh = 64; start_sh = 0; rows_sh = 1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // first eight query elements, extremes at both ends
    for (int d = 0; d < 8; d++)
      send_load(OP_LOAD_Q, 8'($urandom), 2'($urandom), 6'(d),
                (d == 0) ? 16'h7FFF : (d == 7) ? 16'h8000 : 16'($urandom));
    issue_run(0, 1);     // head past query_heads -> error transaction
    issue_run(1, 0);     // row past row_count -> error transaction

    // widest heads, max scale
    configure(32, 4, 2, 0, 4, 65535);
    issue_run(1, 31);
    issue_run(1, 8);
    // derived kv head out of range, zero scale
    configure(5, 2, 2, 3, 3, 0);
    issue_run(2, 4);
    issue_run(1, 3);
    // horizon past the cache -> error transaction
    configure(1, 1, 1, 250, 256, 8192);
    issue_run(6, 0);
    // illegal register combinations, each must give an error transaction
    configure(4, 0, 8, 0, 2, 8192);
    issue_run(0, 0);
    configure(4, 5, 8, 0, 2, 8192);
    issue_run(0, 0);
    configure(2, 3, 8, 0, 2, 8192);
    issue_run(0, 0);
    configure(2, 1, 0, 0, 2, 8192);
    issue_run(1, 1);
    configure(2, 1, 100, 0, 2, 8192);
    issue_run(1, 1);
    configure(0, 1, 8, 0, 2, 8192);
    issue_run(0, 0);
    // writes past the register list must change nothing
    drain();
    write_reg(CFG_UNUSED_LO, 16'hFFFF);
    write_reg(CFG_UNUSED_HI, 16'h0000);

    // ---- random part: four phases of 15 random picks each ----
    for (int ph = 0; ph < 4; ph++) begin
      qh = $urandom_range(1, 32);
      kv = $urandom_range(1, (qh < 4) ? qh : 4);
      configure(qh, kv, $urandom_range(1, 3), $urandom_range(0, 1), $urandom_range(1, 3),
                $urandom);
      if (ph == 3) quiet = 1'b1;
      for (int n = 0; n < 15; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 2)
          send_load(OP_LOAD_Q, 8'($urandom), 2'($urandom), 6'($urandom), 16'($urandom));
        else if (pick < 4)
          send_load($urandom_range(0, 1) ? OP_LOAD_K : OP_LOAD_V, 8'($urandom_range(0, 3)),
                    2'($urandom), 6'($urandom_range(0, 3)), 16'($urandom));
        else if (pick < 5)
          issue_run($urandom_range(0, 255), $urandom_range(0, 31));
        else
          issue_run($urandom_range(0, rows_sh - 1), $urandom_range(0, qheads_sh - 1));
        // once, midway through the second phase, hold off until the pipeline is empty
        if (ph == 1 && n == 7) drain();
      end
    end

    drain();
    $display("Covered %0d run transactions, %0d results (%0d error results).",
             runs_seen, results_seen, err_results);
    $display("Included illegal settings, a horizon past the cache and stall bursts on both sides.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/cgqa_pkg.sv
hdl/cgqa_front.sv
hdl/cgqa_fifo.sv
hdl/cgqa_div.sv
hdl/cgqa_back.sv
hdl/causal_gqa_attention.sv
hdl/cgqa_checker.sv
sim/cgqa_checker.sv
sim/tb_causal_gqa_attention.sv
